[sv/asfp_pkg.sv]
// Shared types and constants of the ASCII sensor frame parser.
`timescale 1ns / 1ps

package asfp_pkg;

    localparam logic [7:0] CHAR_START   = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;

    localparam int VALUE_TOKENS = 9;
    localparam int FIFO_DEPTH   = 4;

    typedef logic [3:0] tok_cnt_t;

    localparam tok_cnt_t TOK_DIGITAL = 4'd5;
    localparam tok_cnt_t TOK_HEX     = 4'd6;
    localparam tok_cnt_t TOK_LAST    = 4'd9;
    localparam tok_cnt_t TOK_DONE    = 4'd10;

    localparam logic [9:0]  TEMP_SCALE  = 10'd825;
    localparam int          TEMP_SHIFT  = 10;
    localparam logic [16:0] TEMP_OFFSET = 17'd500;

    typedef logic [1:0] cmd_kind_t;

    localparam cmd_kind_t CMD_START = 2'd0;
    localparam cmd_kind_t CMD_CHAR  = 2'd1;
    localparam cmd_kind_t CMD_SEP   = 2'd2;
    localparam cmd_kind_t CMD_END   = 2'd3;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       is_dec;
        logic       is_hex;
        logic [3:0] digit;
    } cmd_t;

endpackage

[sv/asfp_byte_if.sv]
// Byte channel: valid/ready handshake carrying one received byte.
`timescale 1ns / 1ps

interface asfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[sv/asfp_result_if.sv]
// Result channel: valid/ready handshake carrying one decoded sensor frame.
`timescale 1ns / 1ps

interface asfp_result_if;
    logic               valid;
    logic               ready;
    logic [15:0]        angle;
    logic [15:0]        light;
    logic [15:0]        analog_one;
    logic [15:0]        analog_two;
    logic               button;
    logic               din_one;
    logic               din_two;
    logic               din_three;
    logic [31:0]        ir_code;
    logic [15:0]        touch_x;
    logic [15:0]        touch_y;
    logic signed [16:0] temp_tenths;

    modport source (output valid, input ready, output angle, output light,
                    output analog_one, output analog_two, output button,
                    output din_one, output din_two, output din_three,
                    output ir_code, output touch_x, output touch_y,
                    output temp_tenths);
    modport sink   (input valid, output ready, input angle, input light,
                    input analog_one, input analog_two, input button,
                    input din_one, input din_two, input din_three,
                    input ir_code, input touch_x, input touch_y,
                    input temp_tenths);
endinterface

[sv/ascii_sensor_frame_parser.sv]
// Top level of the ASCII sensor frame parser.
`timescale 1ns / 1ps

// Takes one received byte per transfer and sustains one byte per clock. A frame
// opens at 'a' and closes at newline; a frame that reaches MAX_FRAME stored bytes
// and receives another non-newline byte is dropped. The front end classifies each
// byte and hands a command to a four-entry queue; the back end pops one command a
// cycle unless a newline's command waits on an untaken result, counts comma tokens
// and accumulates decimal or hexadecimal values. The result appears in the cycle
// after the newline's command leaves the queue and is held in an output register.
// Input ready drops only when the queue is full, which happens when a newline's
// command waits behind an untaken result and the bytes after it fill the queue.

module ascii_sensor_frame_parser import asfp_pkg::*; #(
    parameter int MAX_FRAME = 50
) (
    input  logic clk,
    input  logic rst_n,
    asfp_byte_if.sink     rx,
    asfp_result_if.source res
);

    logic space, push, q_valid, pop;
    cmd_t push_cmd, q_cmd;

    asfp_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .space (space),
        .push  (push),
        .cmd   (push_cmd)
    );

    asfp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .space    (space),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    asfp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .pop     (pop),
        .res     (res)
    );

endmodule

[sv/asfp_front.sv]
// Front end: frame delimiting, length limit and byte classification.
`timescale 1ns / 1ps

module asfp_front import asfp_pkg::*; #(
    parameter int MAX_FRAME = 50
) (
    input  logic  clk,
    input  logic  rst_n,
    asfp_byte_if.sink rx,
    input  logic  space,
    output logic  push,
    output cmd_t  cmd
);

    localparam int CNT_W = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

    logic             in_frame_reg, in_frame_next;
    logic             text_ended_reg, text_ended_next;
    logic [CNT_W-1:0] byte_count_reg, byte_count_next;
    logic             take;
    logic [7:0]       c;
    logic             is_dec, is_low, is_up;

    assign rx.ready = space;
    assign take     = rx.valid && rx.ready;
    assign c        = rx.rx_byte;

    assign is_dec = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign is_low = (c >= CHAR_LOW_A) && (c <= CHAR_LOW_F);
    assign is_up  = (c >= CHAR_UP_A) && (c <= CHAR_UP_F);

    always_comb
    begin
        in_frame_next   = in_frame_reg;
        text_ended_next = text_ended_reg;
        byte_count_next = byte_count_reg;
        push            = 1'b0;
        cmd.kind        = CMD_CHAR;
        cmd.is_dec      = is_dec;
        cmd.is_hex      = is_dec || is_low || is_up;
        cmd.digit       = is_dec ? c[3:0] : 4'(c[3:0] + 4'd9);
        if (take)
        begin
            priority if (!in_frame_reg)
            begin
                if (c == CHAR_START)
                begin
                    in_frame_next   = 1'b1;
                    text_ended_next = 1'b0;
                    byte_count_next = CNT_W'(1);
                    push            = 1'b1;
                    cmd.kind        = CMD_START;
                end
            end
            else if (c == CHAR_NEWLINE)
            begin
                in_frame_next = 1'b0;
                push          = 1'b1;
                cmd.kind      = CMD_END;
            end
            else if (byte_count_reg >= MAX_CNT)
            begin
                in_frame_next = 1'b0;
            end
            else
            begin
                byte_count_next = byte_count_reg + CNT_W'(1);
                if (!text_ended_reg)
                begin
                    push = 1'b1;
                    if (c == CHAR_NUL)
                    begin
                        text_ended_next = 1'b1;
                        cmd.kind        = CMD_SEP;
                    end
                    else if (c == CHAR_COMMA)
                    begin
                        cmd.kind = CMD_SEP;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            text_ended_reg <= 1'b0;
            byte_count_reg <= '0;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            text_ended_reg <= text_ended_next;
            byte_count_reg <= byte_count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= MAX_CNT)
        else $error("frame byte count beyond limit");

    a_drop_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_frame_reg && c != CHAR_NEWLINE && byte_count_reg >= MAX_CNT) |-> !push)
        else $error("overlong byte forwarded");

endmodule

[sv/asfp_cmd_fifo.sv]
// Command queue between the front end and the token back end.
`timescale 1ns / 1ps

module asfp_cmd_fifo import asfp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic space,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FIFO_DEPTH);

    cmd_t             entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign space   = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && space;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + PTR_W'(1));
            end
            if (do_pop)
            begin
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + PTR_W'(1));
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("push into full command queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("command queue count out of range");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == FULL_CNT) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

[sv/asfp_back.sv]
// Back end: token counting, number accumulation and result register.
`timescale 1ns / 1ps

module asfp_back import asfp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic pop,
    asfp_result_if.source res
);

    localparam int SLOT_W = $clog2(VALUE_TOKENS);

    tok_cnt_t    tok_num_reg, tok_num_next;
    logic        nonempty_reg, nonempty_next;
    logic        ended_reg, ended_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] value_reg [VALUE_TOKENS];
    logic        out_valid_reg;

    logic        closing, counted, write_slot, load;
    tok_cnt_t    tok_after;
    logic [SLOT_W-1:0] slot;
    logic        in_range, use_hex, dig_ok;
    logic [35:0] mul_dec, mul_hex, sum;
    logic [31:0] v8;
    logic [15:0] raw;
    logic [25:0] prod;
    logic [16:0] scaled;

    function automatic logic [15:0] sat16(input logic [31:0] v);
        return (v[31:16] != 16'd0) ? 16'hFFFF : v[15:0];
    endfunction

    assign pop = q_valid && ((q_cmd.kind != CMD_END) || !out_valid_reg || res.ready);

    assign closing    = pop && ((q_cmd.kind == CMD_SEP) || (q_cmd.kind == CMD_END));
    assign counted    = nonempty_reg && (tok_num_reg < TOK_DONE);
    assign tok_after  = counted ? tok_num_reg + tok_cnt_t'(1) : tok_num_reg;
    assign write_slot = closing && counted && (tok_num_reg != '0);
    assign slot       = SLOT_W'(tok_num_reg - tok_cnt_t'(1));
    assign load       = pop && (q_cmd.kind == CMD_END) && (tok_after == TOK_DONE);

    assign in_range = (tok_num_reg != '0) && (tok_num_reg <= TOK_LAST);
    assign use_hex  = (tok_num_reg == TOK_HEX);
    assign dig_ok   = use_hex ? q_cmd.is_hex : q_cmd.is_dec;
    assign mul_dec  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                      + {32'd0, q_cmd.digit};
    assign mul_hex  = {acc_reg, q_cmd.digit};
    assign sum      = use_hex ? mul_hex : mul_dec;

    always_comb
    begin
        tok_num_next  = tok_num_reg;
        nonempty_next = nonempty_reg;
        ended_next    = ended_reg;
        acc_next      = acc_reg;
        if (pop)
        begin
            unique case (q_cmd.kind)
                CMD_START:
                begin
                    tok_num_next  = '0;
                    nonempty_next = 1'b1;
                    ended_next    = 1'b0;
                    acc_next      = '0;
                end
                CMD_CHAR:
                begin
                    nonempty_next = 1'b1;
                    if (in_range && !ended_reg)
                    begin
                        if (!dig_ok)
                        begin
                            ended_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = (sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end
                end
                CMD_SEP, CMD_END:
                begin
                    tok_num_next  = tok_after;
                    nonempty_next = 1'b0;
                    ended_next    = 1'b0;
                    acc_next      = '0;
                end
                default:
                begin
                    tok_num_next = tok_num_reg;
                end
            endcase
        end
    end

    // The ninth value is the only slot that can still be open at end of frame.
    assign v8     = write_slot ? acc_reg : value_reg[VALUE_TOKENS-1];
    assign raw    = sat16(v8);
    assign prod   = 26'(raw) * 26'(TEMP_SCALE);
    assign scaled = 17'(prod >> TEMP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (write_slot)
        begin
            value_reg[slot] <= acc_reg;
        end
        if (load)
        begin
            res.angle       <= sat16(value_reg[0]);
            res.light       <= sat16(value_reg[1]);
            res.analog_one  <= sat16(value_reg[2]);
            res.analog_two  <= sat16(value_reg[3]);
            res.button      <= value_reg[TOK_DIGITAL-1][3];
            res.din_one     <= value_reg[TOK_DIGITAL-1][0];
            res.din_two     <= value_reg[TOK_DIGITAL-1][1];
            res.din_three   <= value_reg[TOK_DIGITAL-1][2];
            res.ir_code     <= value_reg[TOK_HEX-1];
            res.touch_x     <= sat16(value_reg[6]);
            res.touch_y     <= sat16(value_reg[7]);
            res.temp_tenths <= signed'(scaled - TEMP_OFFSET);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_num_reg   <= '0;
            nonempty_reg  <= 1'b0;
            ended_reg     <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tok_num_reg  <= tok_num_next;
            nonempty_reg <= nonempty_next;
            ended_reg    <= ended_next;
            acc_reg      <= acc_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid = out_valid_reg;

    a_tok_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tok_num_reg <= TOK_DONE)
        else $error("token count beyond saturation");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> res.ready)
        else $error("result overwritten before transfer");

endmodule

[tb/ascii_sensor_frame_parser_test.sv]
// Self-checking testbench of the ASCII sensor frame parser: directed frames, then random byte streams.
`timescale 1ns / 1ps

module ascii_sensor_frame_parser_test;
    import asfp_pkg::*;

    localparam int MAX_FRAME      = 50;
    localparam int ITEM_TARGET    = 1200;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PRINT_LIMIT    = 100;
    // stands for a zero byte inside directed rows
    localparam logic [7:0] NUL_MARK = 8'h7E;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] light;
        logic [15:0] analog_one;
        logic [15:0] analog_two;
        logic        button;
        logic        din_one;
        logic        din_two;
        logic        din_three;
        logic [31:0] ir_code;
        logic [15:0] touch_x;
        logic [15:0] touch_y;
        logic [16:0] temp_tenths;
    } sensor_frame_t;

    typedef struct {
        string         text;
        bit            typed;
        bit            want;
        sensor_frame_t frame;
    } probe_row_t;

    logic clk;
    logic rst_n;

    asfp_byte_if   rx();
    asfp_result_if res();

    ascii_sensor_frame_parser #(.MAX_FRAME(MAX_FRAME)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    // frame decoder state
    bit          frame_open = 1'b0;
    int unsigned stored_bytes;
    int unsigned fields_done;
    bit          field_has_text;
    bit          field_digits_done;
    bit          text_stopped;
    logic [31:0] field_value [VALUE_TOKENS];

    sensor_frame_t frames_due [$];
    sensor_frame_t due_frame;
    logic [7:0]    outgoing [$];
    probe_row_t    probe_rows [$];

    string bound_values [6] = '{"0", "65535", "65536", "4294967295", "4294967296",
                                "99999999999"};

    int  mismatches   = 0;
    int  bytes_sent   = 0;
    int  frames_owed  = 0;
    int  quiet_cycles = 0;
    bit  steady       = 1'b0;
    bit  hold_req     = 1'b0;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic logic [15:0] clip16(logic [31:0] v);
        return (v > 32'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic int digit_of(logic [7:0] c, bit hex);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c - CHAR_ZERO);
        if (hex && c >= CHAR_LOW_A && c <= CHAR_LOW_F) return int'(c - CHAR_LOW_A) + 10;
        if (hex && c >= CHAR_UP_A && c <= CHAR_UP_F) return int'(c - CHAR_UP_A) + 10;
        return -1;
    endfunction

    function automatic void close_field();
        if (field_has_text && fields_done < TOK_DONE) fields_done++;
        field_has_text    = 1'b0;
        field_digits_done = 1'b0;
    endfunction

    function automatic void take_text(logic [7:0] c);
        bit          hex;
        int          d;
        int          slot;
        logic [63:0] wide;
        if (c == CHAR_NUL) begin
            close_field();
            text_stopped = 1'b1;
            return;
        end
        if (c == CHAR_COMMA) begin
            close_field();
            return;
        end
        field_has_text = 1'b1;
        if (fields_done >= 1 && fields_done <= VALUE_TOKENS && !field_digits_done) begin
            hex  = (fields_done == TOK_HEX);
            d    = digit_of(c, hex);
            slot = fields_done - 1;
            if (d < 0) begin
                field_digits_done = 1'b1;
            end else begin
                wide = 64'(field_value[slot]) * (hex ? 64'd16 : 64'd10) + 64'(d);
                field_value[slot] = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            end
        end
    endfunction

    function automatic bit frame_step(logic [7:0] c, output sensor_frame_t r);
        logic [15:0] raw;
        logic [31:0] bits;
        logic [31:0] scaled;
        r = '0;
        if (!frame_open) begin
            if (c != CHAR_START) return 1'b0;
            frame_open        = 1'b1;
            stored_bytes      = 1;
            fields_done       = 0;
            field_has_text    = 1'b0;
            field_digits_done = 1'b0;
            text_stopped      = 1'b0;
            foreach (field_value[i]) field_value[i] = '0;
            take_text(c);
            return 1'b0;
        end
        if (c == CHAR_NEWLINE) begin
            if (!text_stopped) close_field();
            frame_open = 1'b0;
            if (fields_done < TOK_DONE) return 1'b0;
            bits   = field_value[TOK_DIGITAL - 1];
            raw    = clip16(field_value[VALUE_TOKENS - 1]);
            scaled = (32'(raw) * 32'(TEMP_SCALE)) >> TEMP_SHIFT;
            r.angle       = clip16(field_value[0]);
            r.light       = clip16(field_value[1]);
            r.analog_one  = clip16(field_value[2]);
            r.analog_two  = clip16(field_value[3]);
            r.button      = bits[3];
            r.din_one     = bits[0];
            r.din_two     = bits[1];
            r.din_three   = bits[2];
            r.ir_code     = field_value[TOK_HEX - 1];
            r.touch_x     = clip16(field_value[6]);
            r.touch_y     = clip16(field_value[7]);
            r.temp_tenths = scaled[16:0] - TEMP_OFFSET;
            return 1'b1;
        end
        if (stored_bytes >= MAX_FRAME) begin
            frame_open = 1'b0;
            return 1'b0;
        end
        stored_bytes++;
        if (!text_stopped) take_text(c);
        return 1'b0;
    endfunction

    function automatic sensor_frame_t frame_of(int angle, int light, int an1, int an2,
                                               int dig, logic [31:0] ir, int tx, int ty,
                                               int temp);
        sensor_frame_t f;
        logic [31:0]   bits;
        bits          = dig;
        f.angle       = 16'(angle);
        f.light       = 16'(light);
        f.analog_one  = 16'(an1);
        f.analog_two  = 16'(an2);
        f.button      = bits[3];
        f.din_one     = bits[0];
        f.din_two     = bits[1];
        f.din_three   = bits[2];
        f.ir_code     = ir;
        f.touch_x     = 16'(tx);
        f.touch_y     = 16'(ty);
        f.temp_tenths = 17'(temp);
        return f;
    endfunction

    function automatic probe_row_t checked_row(string text, bit want, sensor_frame_t f);
        probe_row_t row;
        row.text  = text;
        row.typed = 1'b1;
        row.want  = want;
        row.frame = f;
        return row;
    endfunction

    function automatic probe_row_t predicted_row(string text);
        probe_row_t row;
        row.text  = text;
        row.typed = 1'b0;
        row.want  = 1'b0;
        row.frame = '0;
        return row;
    endfunction

    function automatic string filler(int n);
        string s;
        s = "";
        repeat (n) s = {s, "x"};
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic void add_string(string s);
        for (int i = 0; i < s.len(); i++) outgoing.push_back(s[i]);
    endfunction

    function automatic void add_value(int k, bit clean);
        int    pick;
        string s;
        pick = clean ? 0 : $urandom_range(0, 19);
        if (k == TOK_HEX) begin
            if (pick == 15)      s = "FFFFFFFFF";
            else if (pick == 16) s = "0x1F";
            else if (pick == 17) s = $sformatf("%0h", $urandom());
            else if (pick == 18) s = $sformatf("%0hg", $urandom_range(0, 255));
            else                 s = $sformatf("%0h", $urandom_range(0, 65535));
            if ($urandom_range(0, 1) == 1) s = s.toupper();
        end else if (k == TOK_DIGITAL) begin
            s = $sformatf("%0d", (pick < 18) ? $urandom_range(0, 15) : $urandom_range(0, 300));
        end else if (pick < 10 && k == VALUE_TOKENS) begin
            s = $sformatf("%0d", $urandom_range(0, 65535));
        end else if (pick < 12) begin
            s = $sformatf("%0d", $urandom_range(0, 999));
        end else if (pick < 15) begin
            s = $sformatf("%0d", $urandom_range(0, 65535));
        end else if (pick == 15) begin
            s = bound_values[$urandom_range(0, 5)];
        end else if (pick == 16) begin
            s = $sformatf("%0d.%0d", $urandom_range(0, 999), $urandom_range(0, 9));
        end else if (pick == 17) begin
            s = $sformatf("-%0d", $urandom_range(0, 999));
        end else if (pick == 18) begin
            s = $sformatf("000%0d", $urandom_range(0, 99999));
        end else begin
            s = "";
            outgoing.push_back(8'($urandom_range(0, 255)));
        end
        add_string(s);
    endfunction

    // mostly well-formed frames; a few short, long, truncated, overlong or noisy ones
    function automatic void build_frame(bit clean);
        int v;
        int ntok;
        int nul_at;
        v = clean ? 99 : $urandom_range(0, 29);
        if (v == 6) begin
            repeat ($urandom_range(5, 30)) outgoing.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if (!clean && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) outgoing.push_back(8'($urandom_range(0, 255)));
        outgoing.push_back(CHAR_START);
        repeat ($urandom_range(0, 3)) outgoing.push_back(8'($urandom_range(98, 122)));
        if (v == 5) repeat ($urandom_range(35, 60)) outgoing.push_back("x");
        ntok = 9;
        if (v == 0) ntok = $urandom_range(5, 8);
        else if (v == 1) ntok = $urandom_range(10, 12);
        nul_at = (v == 2) ? $urandom_range(1, ntok) : 0;
        for (int k = 1; k <= ntok; k++) begin
            outgoing.push_back(CHAR_COMMA);
            if (!clean && $urandom_range(0, 9) == 0) outgoing.push_back(CHAR_COMMA);
            add_value(k, clean);
            if (k == nul_at) outgoing.push_back(CHAR_NUL);
            if (v == 3 && k == 4) outgoing.push_back(8'($urandom_range(0, 255)));
        end
        if (!clean && $urandom_range(0, 7) == 0) outgoing.push_back(CHAR_COMMA);
        if (v != 4) outgoing.push_back(CHAR_NEWLINE);
    endfunction

    task automatic send_byte(input logic [7:0] b, output bit got, output sensor_frame_t r);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            rx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do @(posedge clk); while (!rx.ready);
        bytes_sent++;
        got = frame_step(b, r);
    endtask

    task automatic send_seq(input bit typed, input bit want, input sensor_frame_t f);
        bit            got;
        sensor_frame_t r;
        foreach (outgoing[i]) begin
            send_byte(outgoing[i], got, r);
            if (typed) begin
                if (want && i == outgoing.size() - 1) begin
                    frames_due.push_back(f);
                    frames_owed++;
                end
            end else if (got) begin
                frames_due.push_back(r);
                frames_owed++;
            end
        end
        outgoing.delete();
    endtask

    task automatic await_results();
        @(negedge clk);
        rx.valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge clk);
    endtask

    // receiver holds off while a run of well-formed frames is offered back to back
    task automatic squeeze();
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (8) begin
            build_frame(1'b1);
            send_seq(1'b0, 1'b0, '0);
        end
        steady = 1'b0;
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic field_check(string name, logic [31:0] got, logic [31:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
    endtask

    initial begin
        int wait_n;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                wait_n   = HOLD_CYCLES;
            end else begin
                wait_n = pick_gap();
            end
            if (wait_n > 0) begin
                res.ready <= 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && res.valid && res.ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("result transfer with no frame pending");
            end else begin
                due_frame = frames_due.pop_front();
                field_check("angle", 32'(res.angle), 32'(due_frame.angle));
                field_check("light", 32'(res.light), 32'(due_frame.light));
                field_check("analog_one", 32'(res.analog_one), 32'(due_frame.analog_one));
                field_check("analog_two", 32'(res.analog_two), 32'(due_frame.analog_two));
                field_check("button", 32'(res.button), 32'(due_frame.button));
                field_check("din_one", 32'(res.din_one), 32'(due_frame.din_one));
                field_check("din_two", 32'(res.din_two), 32'(due_frame.din_two));
                field_check("din_three", 32'(res.din_three), 32'(due_frame.din_three));
                field_check("ir_code", res.ir_code, due_frame.ir_code);
                field_check("touch_x", 32'(res.touch_x), 32'(due_frame.touch_x));
                field_check("touch_y", 32'(res.touch_y), 32'(due_frame.touch_y));
                field_check("temp_tenths", 32'(res.temp_tenths),
                            32'($signed(due_frame.temp_tenths)));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (rx.valid && rx.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [7:0] c;
        int         frame_no;
        rst_n      = 1'b0;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;

        probe_rows.push_back(checked_row("a,0,0,0,0,0,0,0,0,0\n", 1'b1,
            frame_of(0, 0, 0, 0, 0, 32'h0, 0, 0, -500)));
        probe_rows.push_back(checked_row("a,65535,65535,65535,65535,15,FFFFFFFF,1,1,65535\n",
            1'b1, frame_of(65535, 65535, 65535, 65535, 15, 32'hFFFF_FFFF, 1, 1, 52299)));
        probe_rows.push_back(checked_row("a,99999999999,70000,65536,0,16,FFFFFFFFF,0,0,99999\n",
            1'b1, frame_of(65535, 65535, 65535, 0, 16, 32'hFFFF_FFFF, 0, 0, 52299)));
        probe_rows.push_back(checked_row("a,0,0,0,0,9,0,0,0,0\n", 1'b1,
            frame_of(0, 0, 0, 0, 9, 32'h0, 0, 0, -500)));
        probe_rows.push_back(checked_row("a,0,0,0,0,0,0,0,0,1024\n", 1'b1,
            frame_of(0, 0, 0, 0, 0, 32'h0, 0, 0, 325)));
        probe_rows.push_back(predicted_row("a,1,2,3,4,6,aBcDeF01,5,6,1023\n"));
        probe_rows.push_back(predicted_row("a,3,2,1,0,10,0123456789,7,8,9\n"));
        probe_rows.push_back(checked_row("a,1,2,3,4,5,6,7,8\n", 1'b0, '0));
        probe_rows.push_back(predicted_row("a,,1,,2,3,,4,5,6,7,8,9,,\n"));
        probe_rows.push_back(predicted_row("a,1,2,3,4,5,6,7,8,9,10,11\n"));
        probe_rows.push_back(predicted_row("a,12x3,-5, 7,0x1F,3z,1g,7.5,8e2,300\n"));
        probe_rows.push_back(predicted_row("xyz\n\n,5,aa,1,2,3,4,5,6,7,8,9\n"));
        probe_rows.push_back(predicted_row("a,1,2,3,4,5,6,7,8,9~,junk\n"));
        probe_rows.push_back(checked_row("a,1,2,3~4,5,6,7,8,9\n", 1'b0, '0));
        probe_rows.push_back(checked_row({"a", filler(31), ",1,2,3,4,5,6,7,8,9\n"}, 1'b1,
            frame_of(1, 2, 3, 4, 5, 32'h6, 7, 8, -493)));
        probe_rows.push_back(checked_row({"a", filler(32), ",1,2,3,4,5,6,7,8,9\n"}, 1'b0, '0));
        probe_rows.push_back(checked_row({"a", filler(49), "a,1,2,3,4,5,6,7,8,9\n"}, 1'b0, '0));
        probe_rows.push_back(predicted_row({"a", filler(49), "qa,1,2,3,4,5,6,7,8,9\n"}));
        probe_rows.push_back(predicted_row("a,0000000000065535,1,1,1,1,f,1,1,1\n"));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (probe_rows[n]) begin
            for (int i = 0; i < probe_rows[n].text.len(); i++) begin
                c = probe_rows[n].text[i];
                outgoing.push_back((c == NUL_MARK) ? CHAR_NUL : c);
            end
            send_seq(probe_rows[n].typed, probe_rows[n].want, probe_rows[n].frame);
        end

        await_results();
        squeeze();

        frame_no = 0;
        while (bytes_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 7) == 0);
            if (frame_no == 25) squeeze();
            build_frame(1'b0);
            send_seq(1'b0, 1'b0, '0);
            frame_no++;
        end
        steady = 1'b0;

        await_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[ascii_sensor_frame_parser.f]
sv/asfp_pkg.sv
sv/asfp_byte_if.sv
sv/asfp_result_if.sv
sv/asfp_front.sv
sv/asfp_cmd_fifo.sv
sv/asfp_back.sv
sv/ascii_sensor_frame_parser.sv
tb/ascii_sensor_frame_parser_test.sv
